// ----- hdl/rhcn_pkg.sv -----
// rhcn_pkg: shared types, constants and functions for the cartridge header
// check and image normaliser. No dependencies.
`default_nettype none

package rhcn_pkg;

    localparam int unsigned HDR_BYTES       = 16;
    localparam int unsigned BANK_BYTES      = 16384;
    localparam int unsigned PRG_IMAGE_BYTES = 32768;
    localparam int unsigned CHR_IMAGE_BYTES = 8192;
    localparam int unsigned TRAINER_BYTES   = 512;
    localparam int unsigned IMAGE_BYTES     = PRG_IMAGE_BYTES + CHR_IMAGE_BYTES;

    localparam int unsigned CNT_W  = 17;
    localparam int unsigned BANK_W = $clog2(BANK_BYTES);

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    localparam logic [7:0] FLAG_V2_MASK = 8'h0C;
    localparam logic [7:0] FLAG_V2_CODE = 8'h08;
    localparam logic [7:0] FLAG_MAP_HI  = 8'hF0;

    // status codes
    localparam logic [3:0] ST_OK     = 4'd0;
    localparam logic [3:0] ST_SHORT  = 4'd1;
    localparam logic [3:0] ST_MAGIC  = 4'd2;
    localparam logic [3:0] ST_V2     = 4'd3;
    localparam logic [3:0] ST_MAPPER = 4'd4;
    localparam logic [3:0] ST_PRG    = 4'd5;
    localparam logic [3:0] ST_CHR    = 4'd6;
    localparam logic [3:0] ST_FOUR   = 4'd7;
    localparam logic [3:0] ST_LENGTH = 4'd8;

    // result kinds
    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_REPLAY = 5'b00010,
        S_WR1    = 5'b00100,
        S_WR2    = 5'b01000,
        S_STAT   = 5'b10000
    } ctl_state_t;

    typedef struct packed {
        logic accept;      // input beat taken this cycle
        logic replay_run;  // stream the bank buffer into the CRC
        logic crc_held;    // fold the held byte into the CRC
        logic clear;       // status beat taken: back to reset state
        logic sel_wr2;     // output shows the mirrored PRG write
        logic sel_stat;    // output shows the status beat
    } ctl_cmd_t;

    typedef struct packed {
        logic wr;           // offered byte lands in the image
        logic dup;          // ... and is mirrored 16 KiB higher
        logic replay;       // ... and is the first CHR byte after a single bank
        logic replay_done;  // buffer replay finished
    } dp_stat_t;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] m;
        unique case (idx)
            2'd0:    m = 8'h4E;
            2'd1:    m = 8'h45;
            2'd2:    m = 8'h53;
            default: m = 8'h1A;
        endcase
        return m;
    endfunction

    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            r = (r >> 1) ^ (r[0] ? CRC_POLY : 32'd0);
        end
        return r;
    endfunction

    function automatic logic [3:0] header_status(
        input logic       magic_ok,
        input logic [7:0] prg,
        input logic [7:0] chr,
        input logic [7:0] fl,
        input logic [7:0] fh
    );
        logic [3:0] st;
        if (!magic_ok) begin
            st = ST_MAGIC;
        end else if ((fh & FLAG_V2_MASK) == FLAG_V2_CODE) begin
            st = ST_V2;
        end else if (fl[7:4] != 4'd0 || (fh & FLAG_MAP_HI) != 8'd0) begin
            st = ST_MAPPER;
        end else if (prg != 8'd1 && prg != 8'd2) begin
            st = ST_PRG;
        end else if (chr != 8'd1) begin
            st = ST_CHR;
        end else if (fl[3]) begin
            st = ST_FOUR;
        end else begin
            st = ST_OK;
        end
        return st;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/rom_header_check_normalize_core.sv -----
// rom_header_check_normalize_core: top level joining the sequencer and the
// datapath. Depends on rhcn_pkg, rhcn_ctrl and rhcn_datapath.
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------
//  s_      | s_valid / s_ready  | s_in_byte[7:0], s_is_last
//  m_      | m_valid / m_ready  | m_kind, m_image_addr[15:0], m_image_data[7:0],
//          |                    | m_status[3:0], m_mirror_vertical, m_image_crc
//
// A byte that yields no result (header, trainer, surplus) and is not the last
// leaves s_ready high for the next byte. A byte that yields writes and/or the
// status beat drops s_ready until m_ready has taken each of its result beats.
// For a single PRG bank the first CHR byte also replays the 16 KiB buffer into
// the CRC from its one read port, once per file, before its write beats.
// Synchronous active-low reset; the buffer itself is not cleared.
// s_ready and m_valid are never high together; a stalled m_ merely holds.
`default_nettype none

module rom_header_check_normalize_core (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire [7:0]   s_in_byte,
    input  wire         s_is_last,
    output logic        m_valid,
    input  wire         m_ready,
    output logic        m_kind,
    output logic [15:0] m_image_addr,
    output logic [7:0]  m_image_data,
    output logic [3:0]  m_status,
    output logic        m_mirror_vertical,
    output logic [31:0] m_image_crc
);

    rhcn_pkg::ctl_cmd_t cmd;
    rhcn_pkg::dp_stat_t stat;

    rhcn_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_is_last (s_is_last),
        .m_ready   (m_ready),
        .stat      (stat),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .cmd       (cmd)
    );

    rhcn_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_byte    (s_in_byte),
        .cmd        (cmd),
        .stat       (stat),
        .out_kind   (m_kind),
        .out_addr   (m_image_addr),
        .out_data   (m_image_data),
        .out_status (m_status),
        .out_mirror (m_mirror_vertical),
        .out_crc    (m_image_crc)
    );

`ifndef ASSERT_OFF
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and result side active together");

    a_write_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == rhcn_pkg::KIND_WRITE |->
            m_status == rhcn_pkg::ST_OK && m_image_crc == 32'd0 &&
            m_image_addr < 16'(rhcn_pkg::IMAGE_BYTES))
        else $error("write beat with stray status fields or address past image");

    a_status_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_kind == rhcn_pkg::KIND_STATUS |=> s_ready)
        else $error("no new file accepted after status beat");
`endif

endmodule

`default_nettype wire

// ----- hdl/rhcn_datapath.sv -----
// rhcn_datapath: header registers, byte counter, address decode, CRC-32,
// 16 KiB bank buffer with replay counter, result payload. Uses rhcn_pkg.
`default_nettype none

module rhcn_datapath (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire logic [7:0]        in_byte,
    input  wire rhcn_pkg::ctl_cmd_t cmd,
    output rhcn_pkg::dp_stat_t     stat,
    output logic                   out_kind,
    output logic [15:0]            out_addr,
    output logic [7:0]             out_data,
    output logic [3:0]             out_status,
    output logic                   out_mirror,
    output logic [31:0]            out_crc
);

    logic [rhcn_pkg::CNT_W-1:0] count_reg;
    logic                       magic_ok_reg;
    logic [7:0]                 prg_cnt_reg;
    logic [7:0]                 chr_cnt_reg;
    logic [7:0]                 flags_lo_reg;
    logic [7:0]                 flags_hi_reg;
    logic [31:0]                crc_reg;
    logic [7:0]                 byte_reg;
    logic [15:0]                addr_reg;
    logic [rhcn_pkg::BANK_W:0]  rd_cnt_reg;
    logic                       rd_pend_reg;
    logic [7:0]                 rd_data_reg;

    logic [7:0] bank_mem [rhcn_pkg::BANK_BYTES];

    logic                       hdr_phase;
    logic [3:0]                 hdr_st;
    logic [rhcn_pkg::CNT_W-1:0] tr_len;
    logic [rhcn_pkg::CNT_W-1:0] data_start;
    logic [rhcn_pkg::CNT_W-1:0] p_off;
    logic [rhcn_pkg::CNT_W-1:0] prg_len;
    logic [rhcn_pkg::CNT_W-1:0] q_off;
    logic [rhcn_pkg::CNT_W-1:0] expect_len;
    logic                       prg_one;
    logic                       in_data;
    logic                       in_prg;
    logic                       in_chr;
    logic [15:0]                wr_addr;
    logic [3:0]                 final_st;

    assign hdr_phase  = count_reg < rhcn_pkg::CNT_W'(rhcn_pkg::HDR_BYTES);
    assign hdr_st     = rhcn_pkg::header_status(magic_ok_reg, prg_cnt_reg, chr_cnt_reg,
                                                flags_lo_reg, flags_hi_reg);
    assign tr_len     = flags_lo_reg[2] ? rhcn_pkg::CNT_W'(rhcn_pkg::TRAINER_BYTES)
                                        : '0;
    assign data_start = rhcn_pkg::CNT_W'(rhcn_pkg::HDR_BYTES) + tr_len;
    assign p_off      = count_reg - data_start;
    assign prg_one    = prg_cnt_reg == 8'd1;
    assign prg_len    = prg_one ? rhcn_pkg::CNT_W'(rhcn_pkg::BANK_BYTES)
                                : rhcn_pkg::CNT_W'(rhcn_pkg::PRG_IMAGE_BYTES);
    assign q_off      = p_off - prg_len;
    assign in_data    = !hdr_phase && hdr_st == rhcn_pkg::ST_OK && count_reg >= data_start;
    assign in_prg     = p_off < prg_len;
    assign in_chr     = !in_prg && q_off < rhcn_pkg::CNT_W'(rhcn_pkg::CHR_IMAGE_BYTES);
    assign wr_addr    = in_prg ? p_off[15:0]
                               : (16'(rhcn_pkg::PRG_IMAGE_BYTES) | q_off[15:0]);

    assign stat.wr          = in_data && (in_prg || in_chr);
    assign stat.dup         = in_data && in_prg && prg_one;
    assign stat.replay      = in_data && in_chr && prg_one && q_off == '0;
    assign stat.replay_done = rd_cnt_reg[rhcn_pkg::BANK_W] && !rd_pend_reg;

    // final status, from the state left by the last beat
    assign expect_len = data_start + prg_len + rhcn_pkg::CNT_W'(rhcn_pkg::CHR_IMAGE_BYTES);

    always_comb begin
        if (hdr_phase) begin
            final_st = rhcn_pkg::ST_SHORT;
        end else if (hdr_st != rhcn_pkg::ST_OK) begin
            final_st = hdr_st;
        end else if (count_reg != expect_len) begin
            final_st = rhcn_pkg::ST_LENGTH;
        end else begin
            final_st = rhcn_pkg::ST_OK;
        end
    end

    always_comb begin
        if (cmd.sel_stat) begin
            out_kind   = rhcn_pkg::KIND_STATUS;
            out_addr   = '0;
            out_data   = '0;
            out_status = final_st;
            out_mirror = (final_st == rhcn_pkg::ST_OK) && flags_lo_reg[0];
            out_crc    = (final_st == rhcn_pkg::ST_OK) ? ~crc_reg : '0;
        end else begin
            out_kind   = rhcn_pkg::KIND_WRITE;
            out_addr   = cmd.sel_wr2 ? (addr_reg | 16'(rhcn_pkg::BANK_BYTES)) : addr_reg;
            out_data   = byte_reg;
            out_status = rhcn_pkg::ST_OK;
            out_mirror = 1'b0;
            out_crc    = '0;
        end
    end

    // header and counter state
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            count_reg    <= '0;
            magic_ok_reg <= 1'b1;
            prg_cnt_reg  <= '0;
            chr_cnt_reg  <= '0;
            flags_lo_reg <= '0;
            flags_hi_reg <= '0;
        end else if (cmd.accept) begin
            if (count_reg != rhcn_pkg::COUNT_MAX) begin
                count_reg <= count_reg + 1'b1;
            end
            if (count_reg < rhcn_pkg::CNT_W'(4) &&
                in_byte != rhcn_pkg::magic_byte(count_reg[1:0])) begin
                magic_ok_reg <= 1'b0;
            end
            if (count_reg == rhcn_pkg::CNT_W'(4)) prg_cnt_reg  <= in_byte;
            if (count_reg == rhcn_pkg::CNT_W'(5)) chr_cnt_reg  <= in_byte;
            if (count_reg == rhcn_pkg::CNT_W'(6)) flags_lo_reg <= in_byte;
            if (count_reg == rhcn_pkg::CNT_W'(7)) flags_hi_reg <= in_byte;
        end
    end

    // CRC: live image bytes at accept, replayed bank, then the held first CHR byte
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            crc_reg <= rhcn_pkg::CRC_INIT;
        end else if (cmd.accept && stat.wr && !stat.replay) begin
            crc_reg <= rhcn_pkg::crc_byte(crc_reg, in_byte);
        end else if (cmd.crc_held) begin
            crc_reg <= rhcn_pkg::crc_byte(crc_reg, byte_reg);
        end else if (rd_pend_reg) begin
            crc_reg <= rhcn_pkg::crc_byte(crc_reg, rd_data_reg);
        end
    end

    // replay read counter
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.accept) begin
            rd_cnt_reg  <= '0;
            rd_pend_reg <= 1'b0;
        end else if (cmd.replay_run) begin
            rd_pend_reg <= !rd_cnt_reg[rhcn_pkg::BANK_W];
            if (!rd_cnt_reg[rhcn_pkg::BANK_W]) begin
                rd_cnt_reg <= rd_cnt_reg + 1'b1;
            end
        end else begin
            rd_pend_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            byte_reg <= in_byte;
            addr_reg <= wr_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && stat.dup) begin
            bank_mem[p_off[rhcn_pkg::BANK_W-1:0]] <= in_byte;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= bank_mem[rd_cnt_reg[rhcn_pkg::BANK_W-1:0]];
    end

endmodule

`default_nettype wire

// ----- hdl/rhcn_ctrl.sv -----
// rhcn_ctrl: one-hot sequencer for input beats, bank replay and result
// beats. Uses rhcn_pkg; drives rhcn_datapath through ctl_cmd_t.
`default_nettype none

module rhcn_ctrl (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire logic              s_valid,
    input  wire logic              s_is_last,
    input  wire logic              m_ready,
    input  wire rhcn_pkg::dp_stat_t stat,
    output logic                   s_ready,
    output logic                   m_valid,
    output rhcn_pkg::ctl_cmd_t     cmd
);

    rhcn_pkg::ctl_state_t state_reg, state_next;
    logic dup_reg, dup_next;
    logic last_reg, last_next;

    always_comb begin
        state_next = state_reg;
        dup_next   = dup_reg;
        last_next  = last_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            rhcn_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    dup_next   = stat.dup;
                    last_next  = s_is_last;
                    if (stat.replay) begin
                        state_next = rhcn_pkg::S_REPLAY;
                    end else if (stat.wr) begin
                        state_next = rhcn_pkg::S_WR1;
                    end else if (s_is_last) begin
                        state_next = rhcn_pkg::S_STAT;
                    end
                end
            end
            rhcn_pkg::S_REPLAY: begin
                cmd.replay_run = 1'b1;
                if (stat.replay_done) begin
                    cmd.crc_held = 1'b1;
                    state_next   = rhcn_pkg::S_WR1;
                end
            end
            rhcn_pkg::S_WR1: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (dup_reg) begin
                        state_next = rhcn_pkg::S_WR2;
                    end else if (last_reg) begin
                        state_next = rhcn_pkg::S_STAT;
                    end else begin
                        state_next = rhcn_pkg::S_IDLE;
                    end
                end
            end
            rhcn_pkg::S_WR2: begin
                m_valid     = 1'b1;
                cmd.sel_wr2 = 1'b1;
                if (m_ready) begin
                    state_next = last_reg ? rhcn_pkg::S_STAT : rhcn_pkg::S_IDLE;
                end
            end
            rhcn_pkg::S_STAT: begin
                m_valid      = 1'b1;
                cmd.sel_stat = 1'b1;
                if (m_ready) begin
                    cmd.clear  = 1'b1;
                    state_next = rhcn_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = rhcn_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rhcn_pkg::S_IDLE;
            dup_reg   <= 1'b0;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            dup_reg   <= dup_next;
            last_reg  <= last_next;
        end
    end

endmodule

`default_nettype wire
